// ----- design/bh3_pkg.sv -----
// ----------------------------------------------------------------------------
// bh3_pkg
// Shared types, constants and mixing function for the BLAKE3 hash engine.
// ----------------------------------------------------------------------------
package bh3_pkg;

    localparam int MaxStackDepth = 54;

    typedef logic [31:0]       word_t;
    typedef logic [7:0][31:0]  cv_t;
    typedef logic [15:0][31:0] blk_t;

    // Initial vector; element i is IV word i.
    localparam cv_t IV_WORDS = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    localparam int MSG_PERM [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};

    // Domain flags.
    localparam logic [4:0] FLAG_CHUNK_START = 5'd1;
    localparam logic [4:0] FLAG_CHUNK_END   = 5'd2;
    localparam logic [4:0] FLAG_PARENT      = 5'd4;
    localparam logic [4:0] FLAG_ROOT        = 5'd8;
    localparam logic [4:0] FLAG_KEYED       = 5'd16;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEYED_MODE = 3'd0;
    localparam logic [2:0] REG_KEY_0      = 3'd1;
    localparam logic [2:0] REG_KEY_1      = 3'd2;
    localparam logic [2:0] REG_KEY_2      = 3'd3;
    localparam logic [2:0] REG_KEY_3      = 3'd4;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last;
    } item_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    // Request to the compression unit.
    typedef struct packed {
        logic        start;
        cv_t         cv;
        blk_t        blk;
        logic [63:0] ctr;
        logic [6:0]  len;
        logic [4:0]  flags;
    } cmp_req_t;

    // One quarter-round mixing function.
    function automatic quad_t g_fn(input word_t a, input word_t b, input word_t c,
                                   input word_t d, input word_t mx, input word_t my);
        word_t ta;
        word_t tb;
        word_t tc;
        word_t td;
        quad_t r;
        ta = a + b + mx;
        td = d ^ ta;
        td = {td[15:0], td[31:16]};
        tc = c + td;
        tb = b ^ tc;
        tb = {tb[11:0], tb[31:12]};
        ta = ta + tb + my;
        td = td ^ ta;
        td = {td[7:0], td[31:8]};
        tc = tc + td;
        tb = tb ^ tc;
        tb = {tb[6:0], tb[31:7]};
        r.a = ta;
        r.b = tb;
        r.c = tc;
        r.d = td;
        return r;
    endfunction

    // Key words: the key registers in keyed mode, otherwise the IV.
    function automatic cv_t key_words(input logic keyed, input logic [3:0][63:0] key);
        cv_t kw;
        for (int i = 0; i < 4; i++)
        begin
            kw[2*i]   = keyed ? key[i][31:0]  : IV_WORDS[2*i];
            kw[2*i+1] = keyed ? key[i][63:32] : IV_WORDS[2*i+1];
        end
        return kw;
    endfunction

endpackage

// ----- design/bh3_if.sv -----
// ----------------------------------------------------------------------------
// bh3_if
// Channel interfaces: message words in, digests out, configuration writes.
// ----------------------------------------------------------------------------
interface bh3_item_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
    modport source (output valid, data_word, byte_count, last, input ready);
    modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface bh3_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_0;
    logic [63:0] digest_1;
    logic [63:0] digest_2;
    logic [63:0] digest_3;
    modport source (output valid, digest_0, digest_1, digest_2, digest_3, input ready);
    modport sink   (input valid, digest_0, digest_1, digest_2, digest_3, output ready);
endinterface

interface bh3_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/bh3_front.sv -----
// ----------------------------------------------------------------------------
// bh3_front
// Accepts message words, clamps the byte count and queues them two deep.
// ----------------------------------------------------------------------------
module bh3_front
    import bh3_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bh3_item_if.sink     in_ch,
    output item_t        q_item,
    output logic         q_valid,
    input  logic         q_pop
);

    item_t      ent_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    item_t      clamped;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_item      = ent_reg[rptr_reg];

    // A count above eight means a full word.
    always_comb
    begin
        clamped.data_word  = in_ch.data_word;
        clamped.byte_count = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
        clamped.last       = in_ch.last;
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= clamped;
        end
    end

    // Queue pointers and fill.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ----- design/bh3_compress.sv -----
// ----------------------------------------------------------------------------
// bh3_compress
// Seven-round compression, one column or diagonal step of four G per cycle.
// ----------------------------------------------------------------------------
module bh3_compress
    import bh3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cmp_req_t req,
    output logic     done,
    output cv_t      result
);

    localparam logic [3:0] LastStep = 4'd13;

    blk_t       v_reg;
    blk_t       v_next;
    blk_t       m_reg;
    blk_t       m_next;
    logic [3:0] step_reg;
    logic       busy_reg;
    logic       done_reg;
    quad_t      q0;
    quad_t      q1;
    quad_t      q2;
    quad_t      q3;

    assign done = done_reg;

    // Output chaining value.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            result[i] = v_reg[i] ^ v_reg[i+8];
        end
    end

    // One half round; the message is permuted after each diagonal step.
    always_comb
    begin
        v_next = v_reg;
        m_next = m_reg;
        if (!step_reg[0])
        begin
            q0 = g_fn(v_reg[0], v_reg[4], v_reg[8],  v_reg[12], m_reg[0], m_reg[1]);
            q1 = g_fn(v_reg[1], v_reg[5], v_reg[9],  v_reg[13], m_reg[2], m_reg[3]);
            q2 = g_fn(v_reg[2], v_reg[6], v_reg[10], v_reg[14], m_reg[4], m_reg[5]);
            q3 = g_fn(v_reg[3], v_reg[7], v_reg[11], v_reg[15], m_reg[6], m_reg[7]);
            v_next[0] = q0.a; v_next[4] = q0.b; v_next[8]  = q0.c; v_next[12] = q0.d;
            v_next[1] = q1.a; v_next[5] = q1.b; v_next[9]  = q1.c; v_next[13] = q1.d;
            v_next[2] = q2.a; v_next[6] = q2.b; v_next[10] = q2.c; v_next[14] = q2.d;
            v_next[3] = q3.a; v_next[7] = q3.b; v_next[11] = q3.c; v_next[15] = q3.d;
        end
        else
        begin
            q0 = g_fn(v_reg[0], v_reg[5], v_reg[10], v_reg[15], m_reg[8],  m_reg[9]);
            q1 = g_fn(v_reg[1], v_reg[6], v_reg[11], v_reg[12], m_reg[10], m_reg[11]);
            q2 = g_fn(v_reg[2], v_reg[7], v_reg[8],  v_reg[13], m_reg[12], m_reg[13]);
            q3 = g_fn(v_reg[3], v_reg[4], v_reg[9],  v_reg[14], m_reg[14], m_reg[15]);
            v_next[0] = q0.a; v_next[5] = q0.b; v_next[10] = q0.c; v_next[15] = q0.d;
            v_next[1] = q1.a; v_next[6] = q1.b; v_next[11] = q1.c; v_next[12] = q1.d;
            v_next[2] = q2.a; v_next[7] = q2.b; v_next[8]  = q2.c; v_next[13] = q2.d;
            v_next[3] = q3.a; v_next[4] = q3.b; v_next[9]  = q3.c; v_next[14] = q3.d;
            for (int i = 0; i < 16; i++)
            begin
                m_next[i] = m_reg[MSG_PERM[i]];
            end
        end
    end

    // Working state and message.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= req.cv[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                v_reg[i+8] <= IV_WORDS[i];
            end
            v_reg[12] <= req.ctr[31:0];
            v_reg[13] <= req.ctr[63:32];
            v_reg[14] <= {25'd0, req.len};
            v_reg[15] <= {27'd0, req.flags};
            m_reg     <= req.blk;
        end
        else if (busy_reg)
        begin
            v_reg <= v_next;
            m_reg <= m_next;
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 4'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                step_reg <= 4'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == LastStep)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/bh3_back.sv -----
// ----------------------------------------------------------------------------
// bh3_back
// Packs bytes into blocks, sequences chunk and parent compressions, keeps
// the subtree stack and delivers the digest.
// ----------------------------------------------------------------------------
module bh3_back
    import bh3_pkg::*;
#(
    parameter int MAX_STACK_DEPTH = MaxStackDepth
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            q_item,
    input  logic             q_valid,
    output logic             q_pop,
    input  logic             keyed_mode,
    input  logic [3:0][63:0] key,
    bh3_digest_if.source     out_ch
);

    localparam int AW = (MAX_STACK_DEPTH > 1) ? $clog2(MAX_STACK_DEPTH) : 1;
    localparam int DW = $clog2(MAX_STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_APPEND    = 4'd1;
    localparam logic [3:0] S_WAIT_BLK  = 4'd2;
    localparam logic [3:0] S_MERGE     = 4'd3;
    localparam logic [3:0] S_PAR_RD    = 4'd4;
    localparam logic [3:0] S_WAIT_PAR  = 4'd5;
    localparam logic [3:0] S_FINAL     = 4'd6;
    localparam logic [3:0] S_WAIT_FIN  = 4'd7;
    localparam logic [3:0] S_FOLD      = 4'd8;
    localparam logic [3:0] S_FOLD_RD   = 4'd9;
    localparam logic [3:0] S_WAIT_FOLD = 4'd10;
    localparam logic [3:0] S_OUTPUT    = 4'd11;

    logic [3:0]        state_reg,  state_next;
    logic [63:0]       word_reg,   word_next;
    logic [3:0]        rem_reg,    rem_next;
    logic              last_reg,   last_next;
    logic [63:0][7:0]  buf_reg,    buf_next;
    logic [6:0]        fill_reg,   fill_next;
    logic [3:0]        bic_reg,    bic_next;
    logic [63:0]       chunk_reg,  chunk_next;
    logic [63:0]       total_reg,  total_next;
    logic [DW-1:0]     depth_reg,  depth_next;
    cv_t               cv_reg,     cv_next;
    cv_t               cur_reg,    cur_next;
    logic              ovalid_reg, ovalid_next;
    cv_t               dig_reg,    dig_next;

    cv_t               stack_mem [MAX_STACK_DEPTH];
    cv_t               rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;

    cmp_req_t          req;
    logic              cmp_done;
    cv_t               cmp_result;
    cv_t               kw;
    logic [4:0]        base;
    logic [6:0]        space;
    logic [3:0]        n;

    bh3_compress u_compress (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .done   (cmp_done),
        .result (cmp_result)
    );

    assign kw    = key_words(keyed_mode, key);
    assign base  = keyed_mode ? FLAG_KEYED : 5'd0;
    assign space = 7'd64 - fill_reg;
    assign n     = ({3'd0, rem_reg} < space) ? rem_reg : space[3:0];

    assign out_ch.valid    = ovalid_reg;
    assign out_ch.digest_0 = {dig_reg[1], dig_reg[0]};
    assign out_ch.digest_1 = {dig_reg[3], dig_reg[2]};
    assign out_ch.digest_2 = {dig_reg[5], dig_reg[4]};
    assign out_ch.digest_3 = {dig_reg[7], dig_reg[6]};

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        word_next   = word_reg;
        rem_next    = rem_reg;
        last_next   = last_reg;
        buf_next    = buf_reg;
        fill_next   = fill_reg;
        bic_next    = bic_reg;
        chunk_next  = chunk_reg;
        total_next  = total_reg;
        depth_next  = depth_reg;
        cv_next     = cv_reg;
        cur_next    = cur_reg;
        dig_next    = dig_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        req         = '0;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        rd_addr     = AW'(depth_reg - DW'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    word_next  = q_item.data_word;
                    rem_next   = q_item.byte_count;
                    last_next  = q_item.last;
                    q_pop      = 1'b1;
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                if (rem_reg == 4'd0)
                begin
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end
                else if (fill_reg == 7'd64)
                begin
                    // A full block is compressed only when another byte arrives.
                    req.start = 1'b1;
                    req.cv    = (bic_reg == 4'd0) ? kw : cv_reg;
                    req.blk   = blk_t'(buf_reg);
                    req.ctr   = chunk_reg;
                    req.len   = fill_reg;
                    req.flags = base | ((bic_reg == 4'd0) ? FLAG_CHUNK_START : 5'd0)
                                     | ((bic_reg == 4'd15) ? FLAG_CHUNK_END : 5'd0);
                    buf_next   = '0;
                    fill_next  = 7'd0;
                    state_next = S_WAIT_BLK;
                end
                else
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        if (4'(k) < n)
                        begin
                            buf_next[fill_reg[5:0] + 6'(k)] = word_reg[8*k +: 8];
                        end
                    end
                    word_next = word_reg >> {n, 3'b000};
                    rem_next  = rem_reg - n;
                    fill_next = fill_reg + {3'd0, n};
                end
            end
            S_WAIT_BLK:
            begin
                if (cmp_done)
                begin
                    if (bic_reg == 4'd15)
                    begin
                        cur_next   = cmp_result;
                        total_next = chunk_reg + 64'd1;
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        cv_next    = cmp_result;
                        bic_next   = bic_reg + 4'd1;
                        state_next = S_APPEND;
                    end
                end
            end
            S_MERGE:
            begin
                if (!total_reg[0] && (depth_reg != '0))
                begin
                    depth_next = depth_reg - DW'(1);
                    total_next = total_reg >> 1;
                    state_next = S_PAR_RD;
                end
                else
                begin
                    if (depth_reg < DW'(MAX_STACK_DEPTH))
                    begin
                        mem_we     = 1'b1;
                        depth_next = depth_reg + DW'(1);
                    end
                    chunk_next = chunk_reg + 64'd1;
                    bic_next   = 4'd0;
                    state_next = S_APPEND;
                end
            end
            S_PAR_RD:
            begin
                req.start  = 1'b1;
                req.cv     = kw;
                req.blk    = {cur_reg, rd_data_reg};
                req.len    = 7'd64;
                req.flags  = base | FLAG_PARENT;
                state_next = S_WAIT_PAR;
            end
            S_WAIT_PAR:
            begin
                if (cmp_done)
                begin
                    cur_next   = cmp_result;
                    state_next = S_MERGE;
                end
            end
            S_FINAL:
            begin
                req.start = 1'b1;
                req.cv    = (bic_reg == 4'd0) ? kw : cv_reg;
                req.blk   = blk_t'(buf_reg);
                req.ctr   = chunk_reg;
                req.len   = fill_reg;
                req.flags = base | FLAG_CHUNK_END
                                 | ((bic_reg == 4'd0) ? FLAG_CHUNK_START : 5'd0)
                                 | ((depth_reg == '0) ? FLAG_ROOT : 5'd0);
                buf_next   = '0;
                fill_next  = 7'd0;
                state_next = S_WAIT_FIN;
            end
            S_WAIT_FIN:
            begin
                if (cmp_done)
                begin
                    cur_next   = cmp_result;
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                // Fold the stack right to left into parents.
                if (depth_reg == '0)
                begin
                    state_next = S_OUTPUT;
                end
                else
                begin
                    depth_next = depth_reg - DW'(1);
                    state_next = S_FOLD_RD;
                end
            end
            S_FOLD_RD:
            begin
                req.start  = 1'b1;
                req.cv     = kw;
                req.blk    = {cur_reg, rd_data_reg};
                req.len    = 7'd64;
                req.flags  = base | FLAG_PARENT | ((depth_reg == '0) ? FLAG_ROOT : 5'd0);
                state_next = S_WAIT_FOLD;
            end
            S_WAIT_FOLD:
            begin
                if (cmp_done)
                begin
                    cur_next   = cmp_result;
                    state_next = S_FOLD;
                end
            end
            S_OUTPUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    dig_next    = cur_reg;
                    ovalid_next = 1'b1;
                    bic_next    = 4'd0;
                    chunk_next  = 64'd0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Subtree stack memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[depth_reg[AW-1:0]] <= cur_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        rem_reg   <= rem_next;
        last_reg  <= last_next;
        total_reg <= total_next;
        cv_reg    <= cv_next;
        cur_reg   <= cur_next;
        dig_reg   <= dig_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            buf_reg    <= '0;
            fill_reg   <= 7'd0;
            bic_reg    <= 4'd0;
            chunk_reg  <= 64'd0;
            depth_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            buf_reg    <= buf_next;
            fill_reg   <= fill_next;
            bic_reg    <= bic_next;
            chunk_reg  <= chunk_next;
            depth_reg  <= depth_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ----- design/blake3_hash_engine.sv -----
// ----------------------------------------------------------------------------
// blake3_hash_engine
// BLAKE3-256 hash and keyed hash over a stream of 8-byte message words.
//
//   channel  | dir | payload                              | word accepted on
//   in_ch    | in  | data_word, byte_count, last          | valid && ready
//   out_ch   | out | digest_0 .. digest_3                 | valid && ready
//   cfg_ch   | in  | index (0 keyed_mode, 1..4 key_0..3)  | valid && ready
//
// In the back end, a word without a block boundary is popped in S_IDLE
// and packed in S_APPEND. A block compression runs 14 half rounds in the
// G unit between launch and capture; finishing a message adds one parent
// per stack entry. The single compression unit sets the rate. Reset is
// asynchronous and needs no clearing pass. The two-deep input queue keeps
// accepting while a digest waits in the output register.
// ----------------------------------------------------------------------------
module blake3_hash_engine
    import bh3_pkg::*;
#(
    parameter int MAX_STACK_DEPTH = MaxStackDepth
)
(
    input  logic          clk,
    input  logic          rst_n,
    bh3_item_if.sink      in_ch,
    bh3_digest_if.source  out_ch,
    bh3_cfg_if.sink       cfg_ch
);

    logic             keyed_reg;
    logic [3:0][63:0] key_reg;
    item_t            q_item;
    logic             q_valid;
    logic             q_pop;

    assign cfg_ch.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyed_reg <= 1'b0;
            key_reg   <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_KEYED_MODE: keyed_reg  <= cfg_ch.data[0];
                REG_KEY_0:      key_reg[0] <= cfg_ch.data;
                REG_KEY_1:      key_reg[1] <= cfg_ch.data;
                REG_KEY_2:      key_reg[2] <= cfg_ch.data;
                REG_KEY_3:      key_reg[3] <= cfg_ch.data;
                default:        keyed_reg  <= keyed_reg;
            endcase
        end
    end

    bh3_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    bh3_back #(
        .MAX_STACK_DEPTH (MAX_STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .keyed_mode (keyed_reg),
        .key        (key_reg),
        .out_ch     (out_ch)
    );

endmodule

// ----- design/bh3_checker.sv -----
// ----------------------------------------------------------------------------
// bh3_checker
// Port-level checks of the hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module bh3_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_digest_0
);

    logic [2:0] pend_reg;
    logic       in_fin;
    logic       out_acc;

    assign in_fin  = in_valid && in_ready && in_last;
    assign out_acc = out_valid && out_ready;

    // Messages finished at the input whose digest has not left yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_reg + {2'd0, in_fin} - {2'd0, out_acc};
        end
    end

    // No digest is shown while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("digest valid during reset");

    // A stalled digest stays valid and its digest_0 holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_digest_0))
        else $error("stalled digest changed");

    // Every digest belongs to a message already closed at the input.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 3'd0)
        else $error("digest without a finished message");

endmodule

bind blake3_hash_engine bh3_checker u_bh3_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_last      (in_ch.last),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_digest_0 (out_ch.digest_0)
);
